// ===== hw/rtl/grdr_pkg.sv =====
// ----------------------------------------------------------------------------
// grdr_pkg
// Shared types, constants and color math for the glyph row downscale renderer.
// ----------------------------------------------------------------------------
package grdr_pkg;

    // Stream payload widths in bits, each a whole number of bytes.
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    // Output field widths.
    localparam int PIX_COORD_W = 10;
    localparam int COLOR_W     = 16;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    // Register reset values.
    localparam logic [8:0] BORDER_X_RST    = 9'd0;
    localparam logic [8:0] BORDER_Y_RST    = 9'd0;
    localparam logic [4:0] CELL_STEP_X_RST = 5'd4;
    localparam logic [4:0] CELL_STEP_Y_RST = 5'd6;

    // Pixels per drawn glyph row and queue depth between front and back.
    localparam int LANES       = 4;
    localparam int QUEUE_DEPTH = 2;

    // Glyph rows with a special role.
    localparam logic [2:0] GROW_TOP_STORE = 3'd0;
    localparam logic [2:0] GROW_TOP_MERGE = 3'd1;
    localparam logic [2:0] GROW_BOT_STORE = 3'd6;
    localparam logic [2:0] GROW_BOT_MERGE = 3'd7;

    // Cell row of the bottom merged glyph row.
    localparam logic [2:0] BOT_CELL_ROW = 3'd5;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BORDER_X    = 2'd0,
        CFG_BORDER_Y    = 2'd1,
        CFG_CELL_STEP_X = 2'd2,
        CFG_CELL_STEP_Y = 2'd3
    } cfg_idx_t;

    typedef logic [COLOR_W-1:0] rgb565_t;

    // The four pixel colors of one drawn row, lane 0 leftmost.
    typedef logic [LANES-1:0][COLOR_W-1:0] pix_quad_t;

    // Per-channel floor average of two RGB565 colors.
    function automatic rgb565_t blend565(input rgb565_t a, input rgb565_t b);
        logic [5:0] r_sum;
        logic [6:0] g_sum;
        logic [5:0] b_sum;
        r_sum = {1'b0, a[15:11]} + {1'b0, b[15:11]};
        g_sum = {1'b0, a[10:5]} + {1'b0, b[10:5]};
        b_sum = {1'b0, a[4:0]} + {1'b0, b[4:0]};
        return {r_sum[5:1], g_sum[6:1], b_sum[5:1]};
    endfunction

endpackage

// ===== hw/rtl/grdr_front.sv =====
// ----------------------------------------------------------------------------
// grdr_front
// Accepts glyph rows, holds the configuration and the pair line buffer,
// and hands each drawn row to the queue as four colors and a base position.
// ----------------------------------------------------------------------------
module grdr_front #(
    parameter int COORD_WIDTH = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [grdr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [grdr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0 up: glyph_bits(8), glyph_row(3), cell_col(7),
    // cell_row(6), fore_color(16), back_color(16).
    input  logic [grdr_pkg::S_TDATA_W-1:0]    s_tdata,
    // Queue write side.
    output logic                              q_push,
    input  logic                              q_full,
    output grdr_pkg::pix_quad_t               q_colors,
    output logic [COORD_WIDTH-1:0]            q_x0,
    output logic [COORD_WIDTH-1:0]            q_y
);
    import grdr_pkg::*;

    logic [8:0] border_x_reg;
    logic [8:0] border_y_reg;
    logic [4:0] cell_step_x_reg;
    logic [4:0] cell_step_y_reg;

    // Pair averages of the last top or bottom store row; not reset.
    rgb565_t    pair_buf_reg [LANES];

    logic [7:0] glyph_bits;
    logic [2:0] glyph_row;
    logic [6:0] cell_col;
    logic [5:0] cell_row;
    rgb565_t    fore_color;
    rgb565_t    back_color;

    logic       accept;
    logic       store_row;
    logic       merge_row;
    logic [2:0] y_off;
    logic [11:0] x_prod;
    logic [10:0] y_prod;
    logic [12:0] x_sum;
    logic [12:0] y_sum;
    pix_quad_t  pair_colors;

    // Unpack the input transfer.
    assign glyph_bits = s_tdata[7:0];
    assign glyph_row  = s_tdata[10:8];
    assign cell_col   = s_tdata[17:11];
    assign cell_row   = s_tdata[23:18];
    assign fore_color = s_tdata[39:24];
    assign back_color = s_tdata[55:40];

    // Every row needs a free queue slot, so ordering stays trivial.
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign store_row = (glyph_row == GROW_TOP_STORE) || (glyph_row == GROW_BOT_STORE);
    assign merge_row = (glyph_row == GROW_TOP_MERGE) || (glyph_row == GROW_BOT_MERGE);
    assign q_push    = accept && !store_row;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            border_x_reg    <= BORDER_X_RST;
            border_y_reg    <= BORDER_Y_RST;
            cell_step_x_reg <= CELL_STEP_X_RST;
            cell_step_y_reg <= CELL_STEP_Y_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_BORDER_X:    border_x_reg    <= cfg_wdata;
                CFG_BORDER_Y:    border_y_reg    <= cfg_wdata;
                CFG_CELL_STEP_X: cell_step_x_reg <= cfg_wdata[4:0];
                CFG_CELL_STEP_Y: cell_step_y_reg <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // Merge each adjacent pixel pair into one color per lane.
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            pair_colors[k] = blend565(glyph_bits[7-2*k] ? fore_color : back_color,
                                      glyph_bits[6-2*k] ? fore_color : back_color);
        end
    end

    // Merge rows are averaged once more with the stored pair row.
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            q_colors[k] = merge_row ? blend565(pair_colors[k], pair_buf_reg[k])
                                    : pair_colors[k];
        end
    end

    // Line buffer write on store rows.
    always_ff @(posedge aclk) begin
        if (accept && store_row) begin
            for (int k = 0; k < LANES; k++) begin
                pair_buf_reg[k] <= pair_colors[k];
            end
        end
    end

    // Base position of the row; coordinates wrap at COORD_WIDTH bits.
    assign y_off  = (glyph_row == GROW_BOT_MERGE) ? BOT_CELL_ROW : glyph_row - 3'd1;
    assign x_prod = cell_col * cell_step_x_reg;
    assign y_prod = cell_row * cell_step_y_reg;
    assign x_sum  = {1'b0, x_prod} + {4'd0, border_x_reg};
    assign y_sum  = {2'b0, y_prod} + {4'd0, border_y_reg} + {10'd0, y_off};
    assign q_x0   = COORD_WIDTH'(x_sum);
    assign q_y    = COORD_WIDTH'(y_sum);

    // Store rows never reach the queue.
    a_store_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && store_row) |-> !q_push)
        else $error("store row pushed into the queue");

    // A push only happens with room in the queue.
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (s_tvalid && !q_full))
        else $error("push without queue room");

    // Line buffer write and queue push are exclusive.
    a_write_or_push: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && accept && store_row))
        else $error("row both stored and drawn");

endmodule

// ===== hw/rtl/grdr_fifo.sv =====
// ----------------------------------------------------------------------------
// grdr_fifo
// Short queue that decouples row classification from pixel output.
// ----------------------------------------------------------------------------
module grdr_fifo #(
    parameter int DATA_W = 84
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              not_empty
);
    import grdr_pkg::*;

    // Depth is a power of two, so pointers wrap on their own.
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Occupancy update.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue underflow");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== hw/rtl/grdr_back.sv =====
// ----------------------------------------------------------------------------
// grdr_back
// Takes drawn rows from the queue and sends their four pixels, one per cycle while
// the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module grdr_back #(
    parameter int COORD_WIDTH = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Queue read side.
    input  logic                           q_valid,
    output logic                           q_pop,
    input  grdr_pkg::pix_quad_t            q_colors,
    input  logic [COORD_WIDTH-1:0]         q_x0,
    input  logic [COORD_WIDTH-1:0]         q_y,
    // Output stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0 up: pixel_x(10), pixel_y(10), pixel_color(16),
    // then four zero bits.
    output logic [grdr_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import grdr_pkg::*;

    localparam int LANE_W = $clog2(LANES);

    logic                    cur_valid_reg;
    logic [LANE_W-1:0]       lane_reg;
    pix_quad_t               cur_colors_reg;
    logic [COORD_WIDTH-1:0]  cur_x0_reg;
    logic [COORD_WIDTH-1:0]  cur_y_reg;

    logic                    m_valid_reg;
    logic [PIX_COORD_W-1:0]  m_x_reg;
    logic [PIX_COORD_W-1:0]  m_y_reg;
    rgb565_t                 m_color_reg;
    logic                    m_last_reg;

    logic                    out_free;
    logic                    emit;
    logic                    last_emit;
    logic                    load;
    logic [COORD_WIDTH-1:0]  pix_x;

    assign out_free  = !m_valid_reg || m_tready;
    assign emit      = cur_valid_reg && out_free;
    assign last_emit = emit && (lane_reg == LANE_W'(LANES - 1));
    assign load      = q_valid && (!cur_valid_reg || last_emit);
    assign q_pop     = load;
    assign pix_x     = cur_x0_reg + COORD_WIDTH'(lane_reg);

    // Current row and pixel counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            lane_reg      <= '0;
        end else begin
            if (load) begin
                cur_valid_reg <= 1'b1;
                lane_reg      <= '0;
            end else if (last_emit) begin
                cur_valid_reg <= 1'b0;
                lane_reg      <= '0;
            end else if (emit) begin
                lane_reg <= lane_reg + 1'b1;
            end
        end
    end

    // Row payload from the queue.
    always_ff @(posedge aclk) begin
        if (load) begin
            cur_colors_reg <= q_colors;
            cur_x0_reg     <= q_x0;
            cur_y_reg      <= q_y;
        end
    end

    // Output stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output stage payload.
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_x_reg     <= PIX_COORD_W'(pix_x);
            m_y_reg     <= PIX_COORD_W'(cur_y_reg);
            m_color_reg <= cur_colors_reg[lane_reg];
            m_last_reg  <= (lane_reg == LANE_W'(LANES - 1));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_color_reg, m_y_reg, m_x_reg};
    assign m_tlast  = m_last_reg;

    // The pixel counter rests at zero while no row is held.
    a_idle_lane_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !cur_valid_reg |-> (lane_reg == '0))
        else $error("pixel counter moved without a row");

    // A pending non-final pixel means its row is still held.
    a_row_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> cur_valid_reg)
        else $error("row released before its last pixel");

    // Pixels of one row leave without gaps once the sink takes them.
    a_row_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tready && !m_last_reg) |=> m_valid_reg)
        else $error("gap inside a pixel row");

endmodule

// ===== hw/rtl/glyph_row_downscale_renderer.sv =====
// ----------------------------------------------------------------------------
// glyph_row_downscale_renderer
// Renders 8x8 two-color glyph rows as 4x6 RGB565 character cells.
// ----------------------------------------------------------------------------
// Path: the first pixel of a drawn row goes from its input transfer through
// a queue slot, the row register and the output register before it is valid.
// Output: a drawn row sends its four pixels, one per cycle while the sink is
// ready, through the single output register; store rows send nothing.
// Reset: control state, queue and configuration registers are cleared to
// their reset values; the pair line buffer is not reset.
module glyph_row_downscale_renderer #(
    parameter int COORD_WIDTH = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [grdr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [grdr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0 up: glyph_bits(8), glyph_row(3), cell_col(7),
    // cell_row(6), fore_color(16), back_color(16).
    input  logic [grdr_pkg::S_TDATA_W-1:0]    s_tdata,
    // Output stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0 up: pixel_x(10), pixel_y(10), pixel_color(16),
    // then four zero bits.
    output logic [grdr_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);
    import grdr_pkg::*;

    localparam int QUAD_W = LANES * COLOR_W;
    localparam int ENTRY_W = QUAD_W + 2 * COORD_WIDTH;

    logic                   f_push;
    logic                   f_full;
    pix_quad_t              f_colors;
    logic [COORD_WIDTH-1:0] f_x0;
    logic [COORD_WIDTH-1:0] f_y;

    logic                   b_valid;
    logic                   b_pop;
    logic [ENTRY_W-1:0]     b_entry;
    pix_quad_t              b_colors;
    logic [COORD_WIDTH-1:0] b_x0;
    logic [COORD_WIDTH-1:0] b_y;

    // Front: classification, line buffer and base coordinates.
    grdr_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_push    (f_push),
        .q_full    (f_full),
        .q_colors  (f_colors),
        .q_x0      (f_x0),
        .q_y       (f_y)
    );

    // Queue of drawn rows.
    grdr_fifo #(
        .DATA_W (ENTRY_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_push),
        .push_data ({f_y, f_x0, f_colors}),
        .full      (f_full),
        .pop       (b_pop),
        .pop_data  (b_entry),
        .not_empty (b_valid)
    );

    assign b_colors = b_entry[QUAD_W-1:0];
    assign b_x0     = b_entry[QUAD_W +: COORD_WIDTH];
    assign b_y      = b_entry[QUAD_W + COORD_WIDTH +: COORD_WIDTH];

    // Back: pixel serializer and output register.
    grdr_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (b_valid),
        .q_pop    (b_pop),
        .q_colors (b_colors),
        .q_x0     (b_x0),
        .q_y      (b_y),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the glyph row downscale renderer.
// Directed glyph rows, then whole glyphs with random content, broken glyphs
// and loose rows go through the input stream. The sender pauses in random
// gaps and the receiver stalls on its own pattern. Several register
// settings are used, among them the extremes. A scoreboard predicts every
// pixel and compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import grdr_pkg::*;

    localparam int COORD_W      = 10;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_PAUSE  = 8;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_ROWS   = 48;
    localparam int REPORT_LIMIT = 10;

    // One predicted or observed pixel.
    typedef struct packed {
        logic [9:0] x;
        logic [9:0] y;
        rgb565_t    color;
        logic       last;
    } pixel_t;

    // Predicts the pixels of each accepted glyph row and checks the output.
    class pixel_scoreboard;
        logic [8:0] border_x;
        logic [8:0] border_y;
        logic [4:0] step_x;
        logic [4:0] step_y;
        rgb565_t    pair_line [LANES];
        pixel_t     pending [$];
        int         mismatches;

        function new();
            border_x   = BORDER_X_RST;
            border_y   = BORDER_Y_RST;
            step_x     = CELL_STEP_X_RST;
            step_y     = CELL_STEP_Y_RST;
            mismatches = 0;
            foreach (pair_line[k]) pair_line[k] = '0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [8:0] value);
            case (idx)
                CFG_BORDER_X:    border_x = value;
                CFG_BORDER_Y:    border_y = value;
                CFG_CELL_STEP_X: step_x   = value[4:0];
                CFG_CELL_STEP_Y: step_y   = value[4:0];
                default: ;
            endcase
        endfunction

        // Per-channel mean of two colors, rounded down.
        function rgb565_t mix(rgb565_t a, rgb565_t b);
            logic [31:0] red;
            logic [31:0] green;
            logic [31:0] blue;
            red   = (32'(a[15:11]) + 32'(b[15:11])) >> 1;
            green = (32'(a[10:5]) + 32'(b[10:5])) >> 1;
            blue  = (32'(a[4:0]) + 32'(b[4:0])) >> 1;
            return {red[4:0], green[5:0], blue[4:0]};
        endfunction

        function void note_row(logic [S_TDATA_W-1:0] data);
            logic [7:0]  bits;
            logic [2:0]  grow;
            logic [6:0]  col;
            logic [5:0]  row;
            rgb565_t     fg;
            rgb565_t     bg;
            rgb565_t     shade;
            logic [31:0] x0;
            logic [31:0] y0;
            logic [31:0] yoff;
            logic [31:0] coord;
            pixel_t      px;
            {bg, fg, row, col, grow, bits} = data;
            x0 = 32'(border_x) + 32'(col) * 32'(step_x);
            y0 = 32'(border_y) + 32'(row) * 32'(step_y);
            yoff = (grow == GROW_BOT_MERGE) ? 32'(BOT_CELL_ROW) : 32'(grow) - 1;
            for (int k = 0; k < LANES; k++) begin
                shade = mix(bits[7 - 2 * k] ? fg : bg, bits[6 - 2 * k] ? fg : bg);
                if (grow == GROW_TOP_STORE || grow == GROW_BOT_STORE) begin
                    // Store rows only fill the pair line.
                    pair_line[k] = shade;
                end else begin
                    if (grow == GROW_TOP_MERGE || grow == GROW_BOT_MERGE) begin
                        shade = mix(shade, pair_line[k]);
                    end
                    coord    = (x0 + k) & ((32'd1 << COORD_W) - 1);
                    px.x     = coord[9:0];
                    coord    = (y0 + yoff) & ((32'd1 << COORD_W) - 1);
                    px.y     = coord[9:0];
                    px.color = shade;
                    px.last  = (k == LANES - 1);
                    pending.push_back(px);
                end
            end
        endfunction

        function void check_pixel(logic [M_TDATA_W-1:0] data, logic last);
            pixel_t got;
            pixel_t want;
            got.x     = data[9:0];
            got.y     = data[19:10];
            got.color = data[35:20];
            got.last  = last;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected pixel x=%0d y=%0d color=%h last=%0d",
                             got.x, got.y, got.color, got.last);
                end
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("pixel mismatch: expected x=%0d y=%0d color=%h last=%0d,",
                                 want.x, want.y, want.color, want.last,
                                 " got x=%0d y=%0d color=%h last=%0d",
                                 got.x, got.y, got.color, got.last);
                    end
                end
            end
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    cfg_idx_t               cfg_index = CFG_BORDER_X;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    pixel_scoreboard sb = new();
    int idle_cycles = 0;
    int hold_cycles = 0;
    int stall_mode  = 0;
    int stall_phase = 0;
    int burst_left  = 0;
    int rows_sent   = 0;

    glyph_row_downscale_renderer #(
        .COORD_WIDTH(COORD_W)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: a long hold when asked, otherwise a stall pattern that
    // changes now and then.
    always @(posedge aclk) begin
        stall_phase = (stall_phase + 1) % 5;
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 1) == 1);
                default: m_tready <= (stall_phase < 2);
            endcase
        end
        if ($urandom_range(0, 63) == 0) begin
            stall_mode = $urandom_range(0, 3);
        end
    end

    // Transfer monitor and watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_row(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_pixel(m_tdata, m_tlast);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL glyph_row_downscale_renderer");
                $finish;
            end
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_row(logic [7:0] bits, logic [2:0] grow,
                                                      logic [6:0] col, logic [5:0] row,
                                                      rgb565_t fg, rgb565_t bg);
        return {bg, fg, row, col, grow, bits};
    endfunction

    // Offer one row and wait for its transfer; bursts end in random gaps.
    task automatic send_row(input logic [S_TDATA_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        rows_sent++;
    endtask

    // Wait until every predicted pixel has come out and the block is idle.
    // The first edge lets the monitor note the last accepted row.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
    endtask

    // Write all four registers on consecutive cycles.
    task automatic program_regs(input logic [8:0] bx, input logic [8:0] by,
                                input logic [4:0] sx, input logic [4:0] sy);
        logic [8:0] values [4];
        cfg_idx_t   idx;
        values = '{bx, by, 9'(sx), 9'(sy)};
        for (int i = 0; i < 4; i++) begin
            idx = cfg_idx_t'(i);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= values[i];
            sb.write_reg(idx, values[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic rgb565_t random_color();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One glyph in row order; a broken glyph drops some of its rows.
    task automatic send_glyph(input bit broken);
        logic [6:0] col;
        logic [5:0] row;
        rgb565_t    fg;
        rgb565_t    bg;
        logic [7:0] bits;
        col = 7'($urandom);
        row = 6'($urandom);
        fg  = random_color();
        bg  = random_color();
        for (int r = 0; r < 8; r++) begin
            if (!(broken && $urandom_range(0, 3) == 0)) begin
                bits = 8'($urandom);
                if ($urandom_range(0, 9) == 0) begin
                    bits = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                send_row(pack_row(bits, 3'(r), col, row, fg, bg));
            end
        end
    endtask

    // One register setting followed by random glyphs and loose rows.
    task automatic run_phase(input logic [8:0] bx, input logic [8:0] by,
                             input logic [4:0] sx, input logic [4:0] sy,
                             input bit pressure);
        int start;
        int choice;
        drain();
        program_regs(bx, by, sx, sy);
        start = rows_sent;
        while (rows_sent - start < PHASE_ROWS) begin
            if (pressure && rows_sent - start >= 8 && rows_sent - start < 16) begin
                // Long receiver hold while rows keep coming.
                hold_cycles = HOLD_CYCLES;
                pressure = 1'b0;
            end
            choice = $urandom_range(0, 9);
            if (choice < 7) begin
                send_glyph(1'b0);
            end else if (choice < 8) begin
                send_glyph(1'b1);
            end else begin
                send_row(pack_row(8'($urandom), 3'($urandom), 7'($urandom),
                                  6'($urandom), random_color(), random_color()));
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows at reset settings. A store row comes first so the
        // pair line is always written before a merge row reads it.
        send_row(pack_row(8'hFF, GROW_TOP_STORE, 7'd0, 6'd0, 16'hFFFF, 16'h0000));
        send_row(pack_row(8'h00, GROW_TOP_MERGE, 7'd0, 6'd0, 16'hFFFF, 16'h0000));
        send_row(pack_row(8'hAA, 3'd2, 7'd127, 6'd63, 16'hF800, 16'h001F));
        send_row(pack_row(8'h55, 3'd3, 7'd127, 6'd63, 16'h07E0, 16'hF81F));
        send_row(pack_row(8'h96, 3'd4, 7'd127, 6'd63, 16'hFFFF, 16'h0000));
        send_row(pack_row(8'h69, 3'd5, 7'd127, 6'd63, 16'h0000, 16'hFFFF));
        send_row(pack_row(8'hC3, GROW_BOT_STORE, 7'd127, 6'd63, 16'hF800, 16'h07E0));
        send_row(pack_row(8'h3C, GROW_BOT_MERGE, 7'd127, 6'd63, 16'hF800, 16'h07E0));
        // Merge rows out of order reuse whatever the last store row left.
        send_row(pack_row(8'hFF, GROW_BOT_MERGE, 7'd64, 6'd32, 16'h0821, 16'hFFFF));
        send_row(pack_row(8'h0F, GROW_TOP_STORE, 7'd1, 6'd1, 16'h0821, 16'h0000));
        send_row(pack_row(8'hF0, GROW_TOP_MERGE, 7'd1, 6'd1, 16'h0821, 16'h0000));
        send_row(pack_row(8'h00, GROW_BOT_STORE, 7'd5, 6'd7, 16'h1234, 16'hFFFF));
        send_row(pack_row(8'h81, GROW_TOP_MERGE, 7'd5, 6'd7, 16'h1234, 16'hFFFF));
        send_row(pack_row(8'h7E, 3'd5, 7'd100, 6'd40, 16'hFFFF, 16'hFFFF));
        send_row(pack_row(8'h18, 3'd2, 7'd100, 6'd40, 16'h0000, 16'h0000));
        send_row(pack_row(8'hE7, GROW_TOP_STORE, 7'd127, 6'd0, 16'hFFFF, 16'hF81F));
        send_row(pack_row(8'h5A, GROW_BOT_MERGE, 7'd0, 6'd63, 16'h07FF, 16'hF800));

        // Random part over several settings, extremes and out-of-range
        // steps among them.
        run_phase(BORDER_X_RST, BORDER_Y_RST, CELL_STEP_X_RST, CELL_STEP_Y_RST, 1'b1);
        run_phase(9'd511, 9'd511, 5'd16, 5'd16, 1'b0);
        run_phase(9'd0, 9'd0, 5'd1, 5'd1, 1'b0);
        run_phase(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                  5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)), 1'b1);
        run_phase(9'd0, 9'd0, 5'd0, 5'd0, 1'b0);
        run_phase(9'd170, 9'd341, 5'd31, 5'd17, 1'b0);

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS glyph_row_downscale_renderer");
        end else begin
            $display("FAIL glyph_row_downscale_renderer");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/grdr_pkg.sv
hw/rtl/grdr_front.sv
hw/rtl/grdr_fifo.sv
hw/rtl/grdr_back.sv
hw/rtl/glyph_row_downscale_renderer.sv
test/tb.sv
